// ===== design/ideq_pkg.sv =====
// Shared types for the indexed deque engine: operation and status codes,
// and the shift control that the sequencer hands to every storage cell.
// No dependencies.
package ideq_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WORD_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_READ       = 3'd6
  } ideq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } ideq_status_e;

  typedef struct packed {
    logic fire;
    logic open_gap;
    logic close_gap;
  } ideq_shift_t;

endpackage

// ===== design/indexed_deque_engine.sv =====
// Indexed deque engine top level: request decode, a row of storage cells
// and a two-level registered read reduction feeding the result register.
// Depends on ideq_pkg, ideq_ctrl and ideq_cell.
//
//   channel   dir  tdata fields (low bit first)
//   s_axis    in   operation, position, value
//   m_axis    out  data_out, count, status
//
// For each request the cells shift and capture at acceptance, the read word is
// reduced over groups of eight cells into the group registers and then over
// the groups into the result register, which drives m_axis.
// s_axis_tready stays low until the request leaves the second stage.
// Reset clears the count and the pipeline valid bits; cell contents stay.
// A result held by m_axis_tready low lets one more request in, which waits
// in the second stage and stalls s_axis until the held result is taken.
module indexed_deque_engine
  import ideq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // operation, position, value, zero pad
  input  logic [((OP_W+$clog2(DEPTH+1)+WORD_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // data_out, count, status, zero pad
  output logic [((WORD_W+$clog2(DEPTH+1)+STATUS_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned PW     = $clog2(DEPTH + 1);
  localparam int unsigned OUT_BW = ((WORD_W + PW + STATUS_W + 7) / 8) * 8;
  localparam int unsigned GROUPS = (DEPTH + 7) / 8;

  logic [OP_W-1:0]   in_op;
  logic [PW-1:0]     in_pos;
  logic [WORD_W-1:0] in_value;

  assign in_op    = s_axis_tdata[OP_W-1:0];
  assign in_pos   = s_axis_tdata[OP_W+PW-1:OP_W];
  assign in_value = s_axis_tdata[OP_W+PW+WORD_W-1:OP_W+PW];

  logic              fire;
  logic [PW-1:0]     count_q;
  ideq_shift_t       shift;
  logic [PW-1:0]     eff_pos;
  logic [PW-1:0]     count_d;
  ideq_status_e      status;
  logic              rd;

  logic              s1_v_q, s2_v_q, out_v_q;
  logic [PW-1:0]     s1_count_q, s2_count_q;
  ideq_status_e      s1_status_q, s2_status_q;
  logic              s1_rd_q, s2_rd_q;
  logic [WORD_W-1:0] grp_q [GROUPS];
  logic [WORD_W-1:0] out_data_q;
  logic [PW-1:0]     out_count_q;
  ideq_status_e      out_status_q;

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] cell_tap  [DEPTH];
  logic [WORD_W-1:0] grp_d     [GROUPS];
  logic [WORD_W-1:0] red_data;
  logic              s2_adv;
  logic              s1_adv;

  assign s_axis_tready = !s1_v_q && !s2_v_q;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign s2_adv        = s2_v_q && (!out_v_q || m_axis_tready);
  assign s1_adv        = s1_v_q && (!s2_v_q || s2_adv);

  ideq_ctrl #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ctrl (
    .op_i     (in_op),
    .pos_i    (in_pos),
    .count_i  (count_q),
    .fire_i   (fire),
    .shift_o  (shift),
    .pos_o    (eff_pos),
    .count_o  (count_d),
    .status_o (status),
    .rd_o     (rd)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    ideq_cell #(
      .IDX (k),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .pos_i   (eff_pos),
      .count_i (count_q),
      .value_i (in_value),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .tap_o   (cell_tap[k])
    );
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (g * 8 + j < DEPTH) begin
          grp_d[g] = grp_d[g] | cell_tap[g*8+j];
        end
      end
    end
  end

  always_comb begin
    red_data = '0;
    for (int g = 0; g < GROUPS; g++) begin
      red_data = red_data | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_count_q  <= count_d;
      s1_status_q <= status;
      s1_rd_q     <= rd;
    end
    if (s1_adv) begin
      s2_count_q  <= s1_count_q;
      s2_status_q <= s1_status_q;
      s2_rd_q     <= s1_rd_q;
      grp_q       <= grp_d;
    end
    if (s2_adv) begin
      out_data_q   <= s2_rd_q ? red_data : '0;
      out_count_q  <= s2_count_q;
      out_status_q <= s2_status_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_BW'({out_status_q, out_count_q, out_data_q});

endmodule

// ===== design/ideq_cell.sv =====
// One storage cell of the deque row: holds one word, takes the new value or its
// left or right neighbor on insert or remove, and captures itself for a read.
// Depends on ideq_pkg.
module ideq_cell
  import ideq_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 7
) (
  input  logic              clk_i,
  input  ideq_shift_t       shift_i,
  input  logic [PW-1:0]     pos_i,
  input  logic [PW-1:0]     count_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  output logic [WORD_W-1:0] data_o,
  output logic [WORD_W-1:0] tap_o
);

  localparam logic [PW-1:0] IdxV  = PW'(IDX);
  localparam logic [PW-1:0] IdxV1 = PW'(IDX + 1);

  logic [WORD_W-1:0] data_q, data_d;
  logic [WORD_W-1:0] tap_q;

  always_comb begin
    data_d = data_q;
    priority if (shift_i.fire && shift_i.open_gap) begin
      if (IdxV == pos_i) begin
        data_d = value_i;
      end else if (IdxV > pos_i && IdxV <= count_i) begin
        data_d = left_i;
      end
    end else if (shift_i.fire && shift_i.close_gap) begin
      if (IdxV >= pos_i && IdxV1 < count_i) begin
        data_d = right_i;
      end
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (shift_i.fire) begin
      tap_q <= (IdxV == pos_i) ? data_q : '0;
    end
  end

  assign data_o = data_q;
  assign tap_o  = tap_q;

endmodule

// ===== design/ideq_ctrl.sv =====
// Request decoder: resolves the effective index, checks full, empty and
// range, and derives the shift control and the new element count.
// Depends on ideq_pkg.
module ideq_ctrl
  import ideq_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned PW    = 7
) (
  input  logic [OP_W-1:0] op_i,
  input  logic [PW-1:0]   pos_i,
  input  logic [PW-1:0]   count_i,
  input  logic            fire_i,
  output ideq_shift_t     shift_o,
  output logic [PW-1:0]   pos_o,
  output logic [PW-1:0]   count_o,
  output ideq_status_e    status_o,
  output logic            rd_o
);

  localparam logic [PW-1:0] DepthV = PW'(DEPTH);

  logic is_full;
  logic is_empty;

  assign is_full  = (count_i == DepthV);
  assign is_empty = (count_i == '0);

  always_comb begin
    pos_o            = pos_i;
    count_o          = count_i;
    status_o         = ST_OK;
    rd_o             = 1'b0;
    shift_o.fire     = fire_i;
    shift_o.open_gap = 1'b0;
    shift_o.close_gap = 1'b0;
    unique case (op_i)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (op_i == OP_PUSH_BACK) begin
          pos_o = count_i;
        end else if (op_i == OP_PUSH_FRONT) begin
          pos_o = '0;
        end
        if (is_full) begin
          status_o = ST_FULL;
        end else if (pos_o > count_i) begin
          status_o = ST_BAD_INDEX;
        end else begin
          shift_o.open_gap = 1'b1;
          count_o          = count_i + PW'(1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_REMOVE, OP_READ: begin
        if (op_i == OP_POP_BACK) begin
          pos_o = count_i - PW'(1);
        end else if (op_i == OP_POP_FRONT) begin
          pos_o = '0;
        end
        if (is_empty) begin
          status_o = ST_EMPTY;
        end else if (pos_o >= count_i) begin
          status_o = ST_BAD_INDEX;
        end else begin
          rd_o = 1'b1;
          if (op_i != OP_READ) begin
            shift_o.close_gap = 1'b1;
            count_o           = count_i - PW'(1);
          end
        end
      end
      default: begin
        status_o = ST_BAD_INDEX;
      end
    endcase
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for indexed_deque_engine: random and directed deque requests
// on s_axis, results compared against an in-bench deque model on m_axis.
// Depends on ideq_pkg and the indexed_deque_engine RTL.
module testbench;
  import ideq_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned POS_W = $clog2(DEPTH + 1);
  localparam int unsigned IN_W  = ((OP_W + POS_W + WORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((WORD_W + POS_W + STATUS_W + 7) / 8) * 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int unsigned RANDOM_REQS = 700;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned DRAIN_AT = 350;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] val;
    bit                drain_first;
  } deq_req_t;

  typedef struct {
    logic [WORD_W-1:0] data;
    logic [POS_W-1:0]  count;
    ideq_status_e      status;
  } deq_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  deq_req_t req_q[$];
  deq_res_t want_q[$];

  logic [WORD_W-1:0] deque_words[DEPTH];
  int unsigned deque_len = 0;
  int unsigned peak_len = 0;
  int unsigned status_hits[4] = '{0, 0, 0, 0};

  int unsigned n_offered = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_mismatch = 0;
  int unsigned est_len = 0;

  int unsigned gap_left = 0;
  bit          send_calm = 1'b0;
  int unsigned stall_left = 0;
  bit          recv_calm = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  indexed_deque_engine #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  task automatic deque_apply(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos_in,
                             input logic [WORD_W-1:0] val, output deq_res_t res);
    int unsigned at;
    int unsigned k;
    at = pos_in;
    res.data = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (op == OP_PUSH_BACK) at = deque_len;
        else if (op == OP_PUSH_FRONT) at = 0;
        if (deque_len >= DEPTH) res.status = ST_FULL;
        else if (at > deque_len) res.status = ST_BAD_INDEX;
        else begin
          for (k = deque_len; k > at; k--) deque_words[k] = deque_words[k-1];
          deque_words[at] = val;
          deque_len++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_REMOVE, OP_READ: begin
        if (op == OP_POP_BACK) at = deque_len - 1;
        else if (op == OP_POP_FRONT) at = 0;
        if (deque_len == 0) res.status = ST_EMPTY;
        else if (at >= deque_len) res.status = ST_BAD_INDEX;
        else begin
          res.data = deque_words[at];
          if (op != OP_READ) begin
            for (k = at; k + 1 < deque_len; k++) deque_words[k] = deque_words[k+1];
            deque_len--;
          end
        end
      end
      default: res.status = ST_BAD_INDEX;
    endcase
    res.count = POS_W'(deque_len);
    if (deque_len > peak_len) peak_len = deque_len;
    status_hits[res.status]++;
  endtask

  task automatic queue_req(input logic [OP_W-1:0] op, input int unsigned pos,
                           input logic [WORD_W-1:0] val, input bit drain_first);
    deq_req_t r;
    r.op = op;
    r.pos = POS_W'(pos);
    r.val = val;
    r.drain_first = drain_first;
    req_q.insert(req_q.size(), r);
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT:
        if (est_len < DEPTH) est_len++;
      OP_INSERT:
        if (est_len < DEPTH && pos <= est_len) est_len++;
      OP_POP_BACK, OP_POP_FRONT:
        if (est_len > 0) est_len--;
      OP_REMOVE:
        if (est_len > 0 && pos < est_len) est_len--;
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: hold until taken, then idle or offer the next request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || n_accepted == n_offered) begin
        if ($urandom_range(0, 99) < 2) send_calm = !send_calm;
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left--;
        end else if (req_q.size() != 0 && !(req_q[0].drain_first && want_q.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_W'({req_q[0].val, req_q[0].pos, req_q[0].op});
          req_q.delete(0);
          n_offered++;
          gap_left = pick_idle(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 99) < 2) recv_calm = !recv_calm;
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_idle(recv_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left--;
    else if (!hold_done && n_offered >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    deq_res_t want;
    logic [WORD_W-1:0]   got_data;
    logic [POS_W-1:0]    got_count;
    logic [STATUS_W-1:0] got_status;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      deque_apply(s_axis_tdata[OP_W-1:0], s_axis_tdata[OP_W+POS_W-1:OP_W],
                  s_axis_tdata[OP_W+POS_W+WORD_W-1:OP_W+POS_W], want);
      want_q.insert(want_q.size(), want);
      n_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_data = m_axis_tdata[WORD_W-1:0];
      got_count = m_axis_tdata[WORD_W+POS_W-1:WORD_W];
      got_status = m_axis_tdata[WORD_W+POS_W+STATUS_W-1:WORD_W+POS_W];
      n_results++;
      if (want_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("result %0d arrived with none pending: data=%h count=%0d status=%0d",
                   n_results, got_data, got_count, got_status);
      end else begin
        want = want_q[0];
        want_q.delete(0);
        if (got_data !== want.data || got_count !== want.count ||
            got_status !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result %0d: data %h/%h count %0d/%0d status %0d/%0d (want/got)",
                     n_results, want.data, got_data, want.count, got_count,
                     want.status, got_status);
        end
      end
    end
  end

  initial begin
    int unsigned n_real;
    int unsigned phase_left;
    int unsigned grow_pct;
    int unsigned r;
    logic [OP_W-1:0] op;
    int unsigned pos;
    bit drain;

    queue_req(OP_POP_BACK, 0, 32'h0, 1'b0);
    queue_req(OP_POP_FRONT, 0, 32'h0, 1'b0);
    queue_req(OP_REMOVE, 0, 32'h0, 1'b0);
    queue_req(OP_READ, 0, 32'h0, 1'b0);
    queue_req(OP_INSERT, 1, 32'h1234_5678, 1'b0);
    queue_req(OP_UNUSED, 127, 32'hffff_ffff, 1'b0);
    queue_req(OP_PUSH_BACK, 0, 32'h7fff_ffff, 1'b0);
    queue_req(OP_PUSH_FRONT, 0, 32'h8000_0000, 1'b0);
    queue_req(OP_INSERT, 2, 32'hffff_ffff, 1'b0);
    queue_req(OP_INSERT, 1, 32'h0000_0000, 1'b0);
    queue_req(OP_READ, 0, 32'h0, 1'b0);
    queue_req(OP_READ, 3, 32'h0, 1'b0);
    queue_req(OP_READ, 4, 32'h0, 1'b0);
    queue_req(OP_READ, 127, 32'h0, 1'b0);
    queue_req(OP_REMOVE, 127, 32'h0, 1'b0);
    queue_req(OP_INSERT, 127, 32'h5555_aaaa, 1'b0);
    queue_req(OP_INSERT, 5, 32'haaaa_5555, 1'b0);
    queue_req(OP_INSERT, 4, 32'h0000_0001, 1'b0);
    queue_req(OP_REMOVE, 1, 32'h0, 1'b0);
    queue_req(OP_REMOVE, 3, 32'h0, 1'b0);
    queue_req(OP_POP_BACK, 0, 32'h0, 1'b0);
    queue_req(OP_POP_FRONT, 0, 32'h0, 1'b0);
    queue_req(OP_PUSH_FRONT, 0, 32'h0f0f_f0f0, 1'b0);

    n_real = 0;
    phase_left = 0;
    grow_pct = 50;
    while (n_real < RANDOM_REQS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 140);
        r = $urandom_range(0, 2);
        grow_pct = (r == 0) ? 85 : (r == 1) ? 15 : 50;
      end
      phase_left--;
      drain = (n_real == 0 || n_real == DRAIN_AT);
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_UNUSED;
      else if ($urandom_range(0, 99) < grow_pct) begin
        r = $urandom_range(0, 2);
        op = (r == 0) ? OP_PUSH_BACK : (r == 1) ? OP_PUSH_FRONT : OP_INSERT;
      end else begin
        r = $urandom_range(0, 3);
        op = (r == 0) ? OP_POP_BACK : (r == 1) ? OP_POP_FRONT :
             (r == 2) ? OP_REMOVE : OP_READ;
      end
      if ($urandom_range(0, 99) < 12) pos = $urandom_range(0, 127);
      else if (op == OP_INSERT) pos = $urandom_range(0, est_len);
      else pos = (est_len > 0) ? $urandom_range(0, est_len - 1) : 0;
      queue_req(op, pos, $urandom, drain);
      if (op != OP_UNUSED) n_real++;
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || n_accepted != n_offered || want_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (want_q.size() != 0) begin
      n_mismatch += want_q.size();
      $display("%0d results never arrived", want_q.size());
    end

    $display("Served %0d requests with %0d results: %0d ok, %0d empty, %0d full, %0d bad index",
             n_accepted, n_results, status_hits[ST_OK], status_hits[ST_EMPTY],
             status_hits[ST_FULL], status_hits[ST_BAD_INDEX]);
    $display("Peak occupancy %0d of %0d, %0d mismatches", peak_len, DEPTH, n_mismatch);
    if (n_mismatch == 0) begin
      $display("indexed_deque_engine: match");
    end else begin
      $display("indexed_deque_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Timed out after %0d requests and %0d results", n_accepted, n_results);
    $display("indexed_deque_engine: mismatch");
    $finish;
  end

endmodule
